[hdl/windowed_key_debouncer_assert.svh]
// Assertion macros used by the checker file of the key debouncer.
// All macros sample on the rising edge of clock.
`ifndef WINDOWED_KEY_DEBOUNCER_ASSERT_SVH
`define WINDOWED_KEY_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WKD_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define WKD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed: label");

// Next-cycle implication that is also checked during reset.
`define WKD_ASSERT_ALWAYS_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("assertion failed: label");

`endif

[hdl/wkd_pkg.sv]
package wkd_pkg;

   // Number of keys handled in parallel.
   localparam int NUM_KEYS = 4;

   // Width of the key fields in the transaction payloads.
   localparam int MASK_W = 4;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Level counter saturation limits.
   localparam logic signed [6:0] COUNT_MAX = 7'sd63;
   localparam logic signed [6:0] COUNT_MIN = -7'sd63;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESS_THRESHOLD   = 3'd0,
      CSR_RELEASE_THRESHOLD = 3'd1,
      CSR_MIN_GAP_MS        = 3'd2,
      CSR_WINDOW_TICKS      = 3'd3,
      CSR_REPORT_ENABLE     = 3'd4
   } csr_index_type;

   // Configuration register set.
   typedef struct packed {
      logic [5:0]        press_threshold;
      logic signed [6:0] release_threshold;
      logic [15:0]       min_gap_ms;
      logic [5:0]        window_ticks;
      logic              report_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      press_threshold:   6'd5,
      release_threshold: -7'sd5,
      min_gap_ms:        16'd20,
      window_ticks:      6'd20,
      report_enable:     1'b0
   };

   // Input transaction payload.
   typedef struct packed {
      logic        mode;
      logic [3:0]  key_levels;
      logic [31:0] now_ms;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [3:0] changed_mask;
      logic [3:0] pressed_mask;
      logic       running;
   } rsp_type;

   // Per-scan control sent to every key slice.
   typedef struct packed {
      logic update;
      logic first;
   } key_ctl_type;

endpackage

[hdl/wkd_key.sv]
module wkd_key
   import wkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  key_ctl_type ctl,
   input  cfg_type     cfg,
   input  logic        level,
   input  logic [31:0] now_ms,
   output logic        changed,
   output logic        pressed
);

   logic signed [6:0] count_ff, count_in, base;
   logic              pressed_ff, pressed_in;
   logic [31:0]       press_time_ff, press_time_in;
   logic [31:0]       release_time_ff, release_time_in;
   logic              press_ok, release_ok;

   // Integrate the level into the counter, clearing it on the first scan of a window.
   always_comb begin
      base = ctl.first ? 7'sd0 : count_ff;
      if (level) begin
         count_in = (base < COUNT_MAX) ? base + 7'sd1 : base;
      end else begin
         count_in = (base > COUNT_MIN) ? base - 7'sd1 : base;
      end
   end

   // A state change needs the threshold, reporting enabled and the debounce time gone by.
   always_comb begin
      press_ok = level && (count_in >= $signed({1'b0, cfg.press_threshold})) &&
                 !pressed_ff && cfg.report_enable &&
                 ((now_ms - press_time_ff) >= {16'd0, cfg.min_gap_ms});
      release_ok = !level && (count_in <= cfg.release_threshold) &&
                   pressed_ff && cfg.report_enable &&
                   ((now_ms - release_time_ff) >= {16'd0, cfg.min_gap_ms});
      changed         = ctl.update && (press_ok || release_ok);
      pressed_in      = changed ? !pressed_ff : pressed_ff;
      press_time_in   = (ctl.update && press_ok) ? now_ms : press_time_ff;
      release_time_in = (ctl.update && release_ok) ? now_ms : release_time_ff;
      pressed         = pressed_in;
   end

   // Key state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= 7'sd0;
         pressed_ff      <= 1'b0;
         press_time_ff   <= 32'd0;
         release_time_ff <= 32'd0;
      end else begin
         if (ctl.update) begin
            count_ff <= count_in;
         end
         pressed_ff      <= pressed_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
      end
   end

endmodule

[hdl/windowed_key_debouncer.sv]
// Windowed key debouncer. Each accepted transaction is either a pin edge (mode 1),
// which arms a window of window_ticks scans, or a scan tick (mode 0) carrying all key
// levels and the millisecond time. Every transaction produces exactly one result,
// registered on acceptance. A new transaction is accepted in every cycle while
// req_stall is low; all keys update in parallel with a small saturating counter, two
// threshold compares and two 32-bit time-difference compares each. Results pass through a
// two-entry output buffer, so req_stall rises only after a result has waited under
// rsp_stall while a second one arrived behind it. Configuration writes take effect at
// the clock edge that carries them and should be made while the block is idle.
module windowed_key_debouncer
   import wkd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff;
   logic [5:0]  ticks_left_ff, ticks_left_in;
   logic        req_accept, rsp_take;
   key_ctl_type key_ctl;
   logic [NUM_KEYS-1:0] key_level, key_changed, key_pressed;
   rsp_type     result;
   rsp_type     out_ff, skid_ff;
   logic        out_valid_ff, skid_valid_ff;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRESS_THRESHOLD:   cfg_ff.press_threshold   <= csr_wdata[5:0];
            CSR_RELEASE_THRESHOLD: cfg_ff.release_threshold <= $signed(csr_wdata[6:0]);
            CSR_MIN_GAP_MS:        cfg_ff.min_gap_ms        <= csr_wdata;
            CSR_WINDOW_TICKS:      cfg_ff.window_ticks      <= csr_wdata[5:0];
            CSR_REPORT_ENABLE:     cfg_ff.report_enable     <= csr_wdata[0];
            default:               cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // Window tracking: an edge reloads the window, each scan inside it counts down.
   always_comb begin
      key_ctl.update = req_accept && !req_payload.mode && (ticks_left_ff != 6'd0);
      key_ctl.first  = (ticks_left_ff == cfg_ff.window_ticks);
      ticks_left_in  = ticks_left_ff;
      if (req_accept) begin
         if (req_payload.mode) begin
            ticks_left_in = cfg_ff.window_ticks;
         end else if (ticks_left_ff != 6'd0) begin
            ticks_left_in = ticks_left_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_left_ff <= 6'd0;
      end else begin
         ticks_left_ff <= ticks_left_in;
      end
   end

   // One slice per key; keys without a level bit read as low.
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      if (k < MASK_W) begin : g_level
         assign key_level[k] = req_payload.key_levels[k];
      end else begin : g_low
         assign key_level[k] = 1'b0;
      end

      wkd_key u_key (
         .clock   (clock),
         .reset   (reset),
         .ctl     (key_ctl),
         .cfg     (cfg_ff),
         .level   (key_level[k]),
         .now_ms  (req_payload.now_ms),
         .changed (key_changed[k]),
         .pressed (key_pressed[k])
      );
   end

   // Assemble the result masks from the key slices.
   for (genvar m = 0; m < MASK_W; m++) begin : g_mask
      if (m < NUM_KEYS) begin : g_used
         assign result.changed_mask[m] = key_changed[m];
         assign result.pressed_mask[m] = key_pressed[m];
      end else begin : g_unused
         assign result.changed_mask[m] = 1'b0;
         assign result.pressed_mask[m] = 1'b0;
      end
   end
   assign result.running = (ticks_left_in != 6'd0);

   // Two-entry output buffer: the skid entry catches a result while the output waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign req_stall   = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[hdl/wkd_checker.sv]
`include "windowed_key_debouncer_assert.svh"

module wkd_checker
   import wkd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_type                rsp_payload
);

   // A result held under stall stays put.
   `WKD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // The input side only stalls while a result is waiting at the output.
   `WKD_ASSERT_NOW(a_stall_needs_output, req_stall, rsp_valid)

   // Stall rises only after a stalled output took one more transaction behind it.
   `WKD_ASSERT_NOW(a_stall_rise, $rose(req_stall),
                   $past(rsp_valid && rsp_stall && req_valid && !req_stall))

   // Reset empties both buffer entries.
   `WKD_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_valid && !req_stall)

endmodule

bind windowed_key_debouncer wkd_checker u_wkd_checker (.*);
